// File: sv/mfre_pkg.sv
// ============================================================================
// Raster engine package
// Shared command codes, the leftmost pixel bit mask and the command record.
// ============================================================================
package mfre_pkg;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_PIXEL = 3'd1;
    localparam logic [2:0] CMD_LINE  = 3'd2;
    localparam logic [2:0] CMD_RECT  = 3'd3;
    localparam logic [2:0] CMD_FILL  = 3'd4;
    localparam logic [2:0] CMD_CIRC  = 3'd5;
    localparam logic [2:0] CMD_READ  = 3'd6;

    localparam logic [7:0] LEFT_BIT = 8'h80;

    // One command as it travels from the front end to the back end.
    typedef struct packed {
        logic [2:0] kind;
        logic       color;
        logic [7:0] start_x;
        logic [7:0] start_y;
        logic [7:0] end_x;
        logic [7:0] end_y;
        logic [7:0] box_width;
        logic [7:0] box_height;
        logic [7:0] radius;
        logic [9:0] read_index;
    } t_cmd;

endpackage

// File: sv/mfre_if.sv
// ============================================================================
// Raster engine channels
// Valid/ready channels for commands and read results.
// ============================================================================
interface mfre_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       color;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
    logic [7:0] box_width;
    logic [7:0] box_height;
    logic [7:0] radius;
    logic [9:0] read_index;
    modport source (output valid, kind, color, start_x, start_y, end_x, end_y,
                    box_width, box_height, radius, read_index, input ready);
    modport sink (input valid, kind, color, start_x, start_y, end_x, end_y,
                  box_width, box_height, radius, read_index, output ready);
endinterface

interface mfre_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

// File: sv/mono_framebuffer_raster_engine_top.sv
// ============================================================================
// Monochrome frame store raster engine
// Top level: command queue front end and drawing back end.
// ============================================================================
// A clear writes every store byte to zero (1024 at 128x64). Pixels, lines,
// boxes and circles plot each pixel with one store read and one write
// (none if clipped) through the single frame store port, plus stepping;
// a byte read is a single store read. After reset the store is swept to
// zero before the first command runs.
module mono_framebuffer_raster_engine_top #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfre_cmd_if.sink   i_cmd,
    mfre_res_if.source o_res
);
    logic           w_valid, w_pop;
    mfre_pkg::t_cmd w_cmd;

    mfre_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cmd(i_cmd),
        .o_valid(w_valid), .o_cmd(w_cmd), .i_pop(w_pop)
    );

    mfre_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_cmd(w_cmd),
        .o_pop(w_pop), .res(o_res)
    );
endmodule

// File: sv/mfre_front.sv
// ============================================================================
// Raster engine front end
// Accepts command transactions into a two-entry queue for the back end.
// ============================================================================
module mfre_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mfre_cmd_if.sink      cmd,
    output logic          o_valid,
    output mfre_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    mfre_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;

    assign cmd.ready = (r_cnt != 2'd2);
    assign w_push    = cmd.valid && cmd.ready;
    assign o_valid   = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{kind: cmd.kind, color: cmd.color, start_x: cmd.start_x,
                           start_y: cmd.start_y, end_x: cmd.end_x, end_y: cmd.end_y,
                           box_width: cmd.box_width, box_height: cmd.box_height,
                           radius: cmd.radius, read_index: cmd.read_index};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_pop) |=> r_cnt == 2'd2)
        else $error("full queue lost an entry");
endmodule

// File: sv/mfre_back.sv
// ============================================================================
// Raster engine back end
// Sequencer that runs clears, pixels, lines, boxes, circles and byte reads.
// ============================================================================
module mfre_back #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mfre_pkg::t_cmd i_cmd,
    output logic           o_pop,
    mfre_res_if.source     res
);
    localparam int ROW_BYTES   = SCREEN_WIDTH / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
    localparam int AW          = $clog2(STORE_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_SEG   = 4'd2;  // set up next segment
    localparam logic [3:0] S_LINE  = 4'd3;  // line stepper
    localparam logic [3:0] S_CPT   = 4'd4;  // circle point
    localparam logic [3:0] S_RD    = 4'd5;  // plot read
    localparam logic [3:0] S_WR    = 4'd6;  // plot write
    localparam logic [3:0] S_RDB   = 4'd7;  // byte read
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_CSTEP = 4'd9;
    localparam logic [3:0] S_RDW   = 4'd10; // plot read data on its way

    logic [7:0]  r_mem [STORE_BYTES];
    logic [7:0]  r_rdata;
    logic [3:0]  r_st, r_ret;
    mfre_pkg::t_cmd r_c;
    logic [AW:0] r_clr;
    // Plot point and line stepper, signed 11 bits.
    logic signed [10:0] r_px, r_py, r_ax, r_ay, r_bx, r_by, r_dx, r_dy, r_err;
    logic        r_sx, r_sy;
    logic [8:0]  r_bw, r_bh, r_row;
    logic [2:0]  r_seg;
    logic signed [10:0] r_cx, r_cy, r_cerr;
    logic [3:0]  r_pt;
    logic [AW-1:0] r_addr;
    logic [2:0]  r_bit;
    logic        r_ok;
    logic [7:0]  r_out;
    logic        r_ovalid;

    logic signed [10:0] w_e2;
    logic signed [10:0] w_qx, w_qy;
    logic signed [10:0] x0, y0;

    assign res.valid     = r_ovalid;
    assign res.read_data = r_out;
    assign o_pop         = (r_st == S_IDLE) && i_valid && !r_ovalid;
    assign w_e2          = r_err + r_err;
    assign x0            = $signed({3'b0, r_c.start_x});
    assign y0            = $signed({3'b0, r_c.start_y});

    // Circle point selection for the current octant tap.
    always_comb begin
        w_qx = x0; w_qy = y0;
        case (r_pt)
            4'd0:  begin w_qx = x0;        w_qy = y0 + r_cx; end
            4'd1:  begin w_qx = x0;        w_qy = y0 - r_cx; end
            4'd2:  begin w_qx = x0 + r_cx; w_qy = y0; end
            4'd3:  begin w_qx = x0 - r_cx; w_qy = y0; end
            4'd4:  begin w_qx = x0 + r_cx; w_qy = y0 + r_cy; end
            4'd5:  begin w_qx = x0 - r_cx; w_qy = y0 + r_cy; end
            4'd6:  begin w_qx = x0 + r_cx; w_qy = y0 - r_cy; end
            4'd7:  begin w_qx = x0 - r_cx; w_qy = y0 - r_cy; end
            4'd8:  begin w_qx = x0 + r_cy; w_qy = y0 + r_cx; end
            4'd9:  begin w_qx = x0 - r_cy; w_qy = y0 + r_cx; end
            4'd10: begin w_qx = x0 + r_cy; w_qy = y0 - r_cx; end
            4'd11: begin w_qx = x0 - r_cy; w_qy = y0 - r_cx; end
            default: begin w_qx = x0; w_qy = y0; end
        endcase
    end

    // Frame store port: writes for the clear sweep and for plots, and a registered read of the byte at r_addr.
    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR) begin
            r_mem[r_clr[AW-1:0]] <= 8'h00;
        end else if (r_st == S_WR && r_ok) begin
            if (r_c.color) r_mem[r_addr] <= r_rdata | (mfre_pkg::LEFT_BIT >> r_bit);
            else r_mem[r_addr] <= r_rdata & ~(mfre_pkg::LEFT_BIT >> r_bit);
        end
        r_rdata <= r_mem[r_addr];
    end

    // Command sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_ovalid <= 1'b0; r_ret <= S_CLR;
        end else begin
            if (res.valid && res.ready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (o_pop) begin
                        r_c <= i_cmd; r_out <= 8'h00; r_seg <= 3'd0; r_row <= 9'd0;
                        r_clr <= '0;
                        case (i_cmd.kind)
                            mfre_pkg::CMD_CLEAR: r_st <= S_CLR;
                            mfre_pkg::CMD_PIXEL: begin
                                r_px <= $signed({3'b0, i_cmd.start_x});
                                r_py <= $signed({3'b0, i_cmd.start_y});
                                r_ret <= S_OUT; r_st <= S_RD;
                            end
                            mfre_pkg::CMD_LINE, mfre_pkg::CMD_RECT, mfre_pkg::CMD_FILL: begin
                                r_bw <= ({1'b0, i_cmd.start_x} + {1'b0, i_cmd.box_width}
                                    >= 9'(SCREEN_WIDTH))
                                    ? 9'(SCREEN_WIDTH) - {1'b0, i_cmd.start_x}
                                    : {1'b0, i_cmd.box_width};
                                r_bh <= ({1'b0, i_cmd.start_y} + {1'b0, i_cmd.box_height}
                                    >= 9'(SCREEN_HEIGHT))
                                    ? 9'(SCREEN_HEIGHT) - {1'b0, i_cmd.start_y}
                                    : {1'b0, i_cmd.box_height};
                                if (i_cmd.kind != mfre_pkg::CMD_LINE &&
                                    ({1'b0, i_cmd.start_x} >= 9'(SCREEN_WIDTH) ||
                                     {1'b0, i_cmd.start_y} >= 9'(SCREEN_HEIGHT)))
                                    r_st <= S_OUT;
                                else r_st <= S_SEG;
                            end
                            mfre_pkg::CMD_CIRC: begin
                                r_cx <= $signed({3'b0, i_cmd.radius});
                                r_cy <= '0; r_cerr <= '0; r_pt <= 4'd0; r_st <= S_CPT;
                            end
                            mfre_pkg::CMD_READ: begin
                                r_addr <= AW'(i_cmd.read_index);
                                r_st <= S_RDB;
                            end
                            default: r_st <= S_OUT;
                        endcase
                    end
                end
                S_CLR: begin
                    // The sweep after reset returns to idle without a result.
                    r_clr <= r_clr + (AW+1)'(1);
                    if (r_clr == (AW+1)'(STORE_BYTES - 1)) begin
                        r_st  <= (r_ret == S_CLR) ? S_IDLE : S_OUT;
                        r_ret <= S_IDLE;
                    end
                end
                S_SEG: begin
                    // Pick the endpoints of the next segment.
                    r_seg <= r_seg + 3'd1;
                    if (r_c.kind == mfre_pkg::CMD_LINE) begin
                        r_ax <= x0; r_ay <= y0;
                        r_bx <= $signed({3'b0, r_c.end_x});
                        r_by <= $signed({3'b0, r_c.end_y});
                        r_st <= (r_seg != 3'd0) ? S_OUT : S_LINE;
                    end else if (r_c.kind == mfre_pkg::CMD_FILL) begin
                        r_ax <= x0; r_bx <= x0 + $signed({2'b0, r_bw});
                        r_ay <= y0 + $signed({2'b0, r_row});
                        r_by <= y0 + $signed({2'b0, r_row});
                        r_row <= r_row + 9'd1;
                        r_st <= (r_row > r_bh) ? S_OUT : S_LINE;
                    end else begin
                        case (r_seg)
                            3'd0: begin r_ax <= x0; r_ay <= y0;
                                r_bx <= x0 + $signed({2'b0, r_bw}); r_by <= y0;
                                r_st <= S_LINE; end
                            3'd1: begin r_ax <= x0; r_ay <= y0 + $signed({2'b0, r_bh});
                                r_bx <= x0 + $signed({2'b0, r_bw});
                                r_by <= y0 + $signed({2'b0, r_bh});
                                r_st <= S_LINE; end
                            3'd2: begin r_ax <= x0; r_ay <= y0; r_bx <= x0;
                                r_by <= y0 + $signed({2'b0, r_bh});
                                r_st <= S_LINE; end
                            3'd3: begin r_ax <= x0 + $signed({2'b0, r_bw}); r_ay <= y0;
                                r_bx <= x0 + $signed({2'b0, r_bw});
                                r_by <= y0 + $signed({2'b0, r_bh});
                                r_st <= S_LINE; end
                            default: r_st <= S_OUT;
                        endcase
                    end
                    r_err <= 11'sd0; r_dx <= 11'sh400; // marks set-up pending
                end
                S_LINE: begin
                    if (r_dx == 11'sh400) begin
                        // Stepper set-up.
                        r_dx  <= (r_bx >= r_ax) ? r_bx - r_ax : r_ax - r_bx;
                        r_dy  <= (r_by >= r_ay) ? r_by - r_ay : r_ay - r_by;
                        r_err <= ((r_bx >= r_ax) ? r_bx - r_ax : r_ax - r_bx)
                               - ((r_by >= r_ay) ? r_by - r_ay : r_ay - r_by);
                        r_sx  <= r_ax < r_bx;
                        r_sy  <= r_ay < r_by;
                        r_px <= r_ax; r_py <= r_ay; r_ret <= S_LINE; r_st <= S_RD;
                    end else if (r_ax == r_bx && r_ay == r_by) begin
                        r_st <= S_SEG;
                    end else begin
                        logic signed [10:0] v_err, v_ax, v_ay;
                        v_err = r_err; v_ax = r_ax; v_ay = r_ay;
                        if (w_e2 > -r_dy) begin
                            v_err = v_err - r_dy; v_ax = r_sx ? r_ax + 11'sd1 : r_ax - 11'sd1;
                        end
                        if (w_e2 < r_dx) begin
                            v_err = v_err + r_dx; v_ay = r_sy ? r_ay + 11'sd1 : r_ay - 11'sd1;
                        end
                        r_err <= v_err; r_ax <= v_ax; r_ay <= v_ay;
                        r_px <= v_ax; r_py <= v_ay; r_ret <= S_LINE; r_st <= S_RD;
                    end
                end
                S_CPT: begin
                    if (r_pt >= 4'd4 && r_cx < r_cy) begin
                        r_st <= S_OUT;
                    end else begin
                        r_px <= w_qx; r_py <= w_qy;
                        r_ret <= (r_pt == 4'd11) ? S_CSTEP : S_CPT;
                        r_pt <= r_pt + 4'd1; r_st <= S_RD;
                    end
                end
                S_CSTEP: begin
                    logic signed [10:0] v_e, v_x;
                    v_e = r_cerr + 11'sd1 + ((r_cy + 11'sd1) <<< 1);
                    v_x = r_cx;
                    if (((v_e - r_cx) <<< 1) + 11'sd1 > 0) begin
                        v_x = r_cx - 11'sd1;
                        v_e = v_e + 11'sd1 - (v_x <<< 1);
                    end
                    r_cy <= r_cy + 11'sd1; r_cerr <= v_e; r_cx <= v_x;
                    r_pt <= 4'd4; r_st <= S_CPT;
                end
                S_RD: begin
                    // Clip and address the pixel; store read follows.
                    r_ok <= (r_px >= 0) && (r_px < 11'(SCREEN_WIDTH))
                         && (r_py >= 0) && (r_py < 11'(SCREEN_HEIGHT));
                    r_addr <= AW'(r_py * 11'(ROW_BYTES) + (r_px >>> 3));
                    r_bit <= r_px[2:0];
                    r_st <= S_RDW;
                end
                S_RDW: begin
                    // The store read of the new address lands this cycle.
                    r_ok <= r_ok && ({1'b0, r_addr} < (AW+1)'(STORE_BYTES));
                    r_st <= S_WR;
                end
                S_WR: begin
                    r_st <= (r_ret == S_WR) ? S_OUT : r_ret;
                end
                S_RDB: begin
                    r_st <= S_OUT + 4'd0;
                    r_ret <= S_RDB;
                end
                S_OUT: begin
                    if (r_ret == S_RDB && r_c.kind == mfre_pkg::CMD_READ)
                        r_out <= ({22'b0, r_c.read_index} < 32'(STORE_BYTES)) ? r_rdata : 8'h00;
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1; r_st <= S_IDLE; r_ret <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !res.ready) |=> r_ovalid)
        else $error("result dropped");
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_ovalid)
        else $error("accepted with result pending");
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_WR) |-> $past(r_st) == S_RDW)
        else $error("write without read");
endmodule

// File: test/mfre_checker.sv
// ============================================================================
// Raster engine checker
// Watches the command and result channels, keeps a private copy of the frame
// store and compares every read result with the predicted byte.
// ============================================================================
`timescale 1ns / 100ps

module mfre_checker #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mfre_cmd_if  i_cmd,
    mfre_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int ROW_BYTES   = SCREEN_WIDTH / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;

    logic [7:0] shadow_store [STORE_BYTES];
    logic [7:0] expected_bytes [$];
    int         fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_bytes.size();

    initial begin
        foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Sets or clears one pixel; pixels off the screen are dropped.
    function automatic void put_pixel(input logic color, input int x, input int y);
        int addr;
        logic [7:0] mask;
        if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return;
        addr = y * ROW_BYTES + x / 8;
        if (addr >= STORE_BYTES) return;
        mask = mfre_pkg::LEFT_BIT >> (x % 8);
        if (color) shadow_store[addr] = shadow_store[addr] | mask;
        else       shadow_store[addr] = shadow_store[addr] & ~mask;
    endfunction

    // Bresenham line from (ax,ay) to (bx,by), both ends included.
    function automatic void draw_line(input logic color, input int ax, input int ay,
                                      input int bx, input int by);
        int dx, dy, step_x, step_y, err, e2;
        dx = (bx >= ax) ? bx - ax : ax - bx;
        dy = (by >= ay) ? by - ay : ay - by;
        step_x = (ax < bx) ? 1 : -1;
        step_y = (ay < by) ? 1 : -1;
        err = dx - dy;
        forever begin
            put_pixel(color, ax, ay);
            if (ax == bx && ay == by) break;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                ax += step_x;
            end
            if (e2 < dx) begin
                err += dx;
                ay += step_y;
            end
        end
    endfunction

    // Midpoint circle outline in eight octants.
    function automatic void draw_circle(input logic color, input int cx, input int cy,
                                        input int r);
        int px, py, err;
        px = r;
        py = 0;
        err = 0;
        put_pixel(color, cx, cy + r);
        put_pixel(color, cx, cy - r);
        put_pixel(color, cx + r, cy);
        put_pixel(color, cx - r, cy);
        while (px >= py) begin
            put_pixel(color, cx + px, cy + py);
            put_pixel(color, cx - px, cy + py);
            put_pixel(color, cx + px, cy - py);
            put_pixel(color, cx - px, cy - py);
            put_pixel(color, cx + py, cy + px);
            put_pixel(color, cx - py, cy + px);
            put_pixel(color, cx + py, cy - px);
            put_pixel(color, cx - py, cy - px);
            py++;
            err += 1 + 2 * py;
            if (2 * (err - px) + 1 > 0) begin
                px--;
                err += 1 - 2 * px;
            end
        end
    endfunction

    // Applies one command to the shadow store and returns the byte it reads.
    function automatic logic [7:0] raster_command(input mfre_pkg::t_cmd c);
        int sx, sy, bw, bh;
        logic [7:0] data;
        sx = int'(c.start_x);
        sy = int'(c.start_y);
        bw = int'(c.box_width);
        bh = int'(c.box_height);
        data = 8'h00;
        // Boxes are clipped so that the far edge lands just off the screen.
        if (sx + bw >= SCREEN_WIDTH) bw = SCREEN_WIDTH - sx;
        if (sy + bh >= SCREEN_HEIGHT) bh = SCREEN_HEIGHT - sy;
        case (c.kind)
            mfre_pkg::CMD_CLEAR: begin
                foreach (shadow_store[i]) shadow_store[i] = 8'h00;
            end
            mfre_pkg::CMD_PIXEL: put_pixel(c.color, sx, sy);
            mfre_pkg::CMD_LINE:
                draw_line(c.color, sx, sy, int'(c.end_x), int'(c.end_y));
            mfre_pkg::CMD_RECT: begin
                if (sx < SCREEN_WIDTH && sy < SCREEN_HEIGHT) begin
                    draw_line(c.color, sx, sy, sx + bw, sy);
                    draw_line(c.color, sx, sy + bh, sx + bw, sy + bh);
                    draw_line(c.color, sx, sy, sx, sy + bh);
                    draw_line(c.color, sx + bw, sy, sx + bw, sy + bh);
                end
            end
            mfre_pkg::CMD_FILL: begin
                if (sx < SCREEN_WIDTH && sy < SCREEN_HEIGHT)
                    for (int i = 0; i <= bh; i++)
                        draw_line(c.color, sx, sy + i, sx + bw, sy + i);
            end
            mfre_pkg::CMD_CIRC: draw_circle(c.color, sx, sy, int'(c.radius));
            mfre_pkg::CMD_READ: begin
                if (int'(c.read_index) < STORE_BYTES) data = shadow_store[c.read_index];
            end
            default: ;
        endcase
        return data;
    endfunction

    // Each command transaction queues exactly one expected byte.
    always @(posedge i_clk) begin
        mfre_pkg::t_cmd c;
        if (i_rst_n && i_cmd.valid && i_cmd.ready) begin
            c.kind       = i_cmd.kind;
            c.color      = i_cmd.color;
            c.start_x    = i_cmd.start_x;
            c.start_y    = i_cmd.start_y;
            c.end_x      = i_cmd.end_x;
            c.end_y      = i_cmd.end_y;
            c.box_width  = i_cmd.box_width;
            c.box_height = i_cmd.box_height;
            c.radius     = i_cmd.radius;
            c.read_index = i_cmd.read_index;
            expected_bytes.push_back(raster_command(c));
        end
    end

    // Each result transaction is matched against the oldest expected byte.
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && i_res.valid && i_res.ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected result %02h", i_res.read_data));
            end else begin
                want = expected_bytes.pop_front();
                if (i_res.read_data !== want)
                    report_mismatch($sformatf("read_data %02h, predicted %02h",
                                              i_res.read_data, want));
            end
        end
    end

endmodule

// File: test/testbench.sv
// ============================================================================
// Raster engine testbench
// Drives directed and random drawing commands with random idling on both
// channels; the checker predicts every result and counts mismatches.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_ITEMS = 1750;
    localparam int IDLE_LIMIT   = 200000;
    // Command code that the block leaves unused.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   idle_cycles = 0;

    mfre_cmd_if cmd ();
    mfre_res_if res ();

    mono_framebuffer_raster_engine_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd.sink),
        .o_res   (res.source)
    );

    mfre_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result receiver stalls at random.
    initial res.ready = 1'b0;
    always @(posedge i_clk) begin
        res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sends one command transaction, with a random gap before it.
    task automatic send_command(input mfre_pkg::t_cmd c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid      <= 1'b1;
        cmd.kind       <= c.kind;
        cmd.color      <= c.color;
        cmd.start_x    <= c.start_x;
        cmd.start_y    <= c.start_y;
        cmd.end_x      <= c.end_x;
        cmd.end_y      <= c.end_y;
        cmd.box_width  <= c.box_width;
        cmd.box_height <= c.box_height;
        cmd.radius     <= c.radius;
        cmd.read_index <= c.read_index;
        do @(posedge i_clk); while (!cmd.ready);
    endtask

    // Builds a command with every field random, the used ones shaped.
    function automatic mfre_pkg::t_cmd random_command();
        mfre_pkg::t_cmd c;
        int pick;
        c = mfre_pkg::t_cmd'(70'({$urandom, $urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 35)      c.kind = mfre_pkg::CMD_READ;
        else if (pick < 50) c.kind = mfre_pkg::CMD_PIXEL;
        else if (pick < 62) c.kind = mfre_pkg::CMD_LINE;
        else if (pick < 72) c.kind = mfre_pkg::CMD_RECT;
        else if (pick < 82) c.kind = mfre_pkg::CMD_FILL;
        else if (pick < 94) c.kind = mfre_pkg::CMD_CIRC;
        else if (pick < 96) c.kind = mfre_pkg::CMD_CLEAR;
        else                c.kind = CMD_UNUSED;
        // Mostly near the screen, sometimes anywhere.
        if ($urandom_range(0, 9) != 0) begin
            c.start_x = 8'($urandom_range(0, 140));
            c.start_y = 8'($urandom_range(0, 75));
            c.end_x   = 8'($urandom_range(0, 140));
            c.end_y   = 8'($urandom_range(0, 75));
        end
        // Boxes and circles stay small apart from a few large ones.
        if ($urandom_range(0, 49) != 0) begin
            c.box_width  = 8'($urandom_range(0, 20));
            c.box_height = 8'($urandom_range(0, 12));
            c.radius     = 8'($urandom_range(0, 40));
        end
        return c;
    endfunction

    function automatic mfre_pkg::t_cmd make_cmd(input logic [2:0] kind, input int color,
                                                input int sx, input int sy, input int ex,
                                                input int ey, input int w, input int h,
                                                input int r, input int idx);
        mfre_pkg::t_cmd c;
        c.kind = kind;
        c.color = 1'(color);
        c.start_x = 8'(sx);
        c.start_y = 8'(sy);
        c.end_x = 8'(ex);
        c.end_y = 8'(ey);
        c.box_width = 8'(w);
        c.box_height = 8'(h);
        c.radius = 8'(r);
        c.read_index = 10'(idx);
        return c;
    endfunction

    initial begin
        mfre_pkg::t_cmd directed [$];
        int n;
        cmd.valid = 1'b0;
        cmd.kind = mfre_pkg::CMD_CLEAR;
        cmd.color = 1'b0;
        cmd.start_x = '0;
        cmd.start_y = '0;
        cmd.end_x = '0;
        cmd.end_y = '0;
        cmd.box_width = '0;
        cmd.box_height = '0;
        cmd.radius = '0;
        cmd.read_index = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, off-screen points, clipping, zero radius, unused kind.
        directed.push_back(make_cmd(mfre_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023));
        directed.push_back(make_cmd(mfre_pkg::CMD_PIXEL, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_PIXEL, 1, 127, 63, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_PIXEL, 1, 128, 0, 255, 255, 255, 255,
                                    255, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_PIXEL, 1, 255, 255, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 1023));
        directed.push_back(make_cmd(mfre_pkg::CMD_LINE, 1, 0, 0, 127, 63, 0, 0, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_LINE, 0, 127, 63, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_LINE, 1, 255, 0, 0, 255, 0, 0, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 17));
        directed.push_back(make_cmd(mfre_pkg::CMD_RECT, 1, 128, 0, 0, 0, 5, 5, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_RECT, 1, 120, 60, 0, 0, 20, 20, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1007));
        directed.push_back(make_cmd(mfre_pkg::CMD_FILL, 1, 3, 2, 0, 0, 10, 3, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_FILL, 1, 0, 64, 0, 0, 4, 4, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 32));
        directed.push_back(make_cmd(mfre_pkg::CMD_CIRC, 1, 5, 5, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_CIRC, 1, 0, 0, 0, 0, 0, 0, 10, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_CIRC, 1, 255, 255, 0, 0, 0, 0, 255, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 80));
        directed.push_back(make_cmd(CMD_UNUSED, 1, 9, 9, 0, 0, 0, 0, 0, 5));
        directed.push_back(make_cmd(mfre_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(mfre_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (directed[i]) send_command(directed[i]);

        // Random commands through four idling phases.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / 100) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            send_command(random_command());
        end
        cmd.valid <= 1'b0;

        // Drain the remaining results.
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
